// File: design/imu_sfp_pkg.sv
// ----------------------------------------------------------------------------
// imu_sfp_pkg
// Shared types and constants for the IMU serial frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_sfp_pkg;

   // default frame length in bytes (header .. checksum)
   localparam int FRAME_LEN_DEF = 11;

   // bytes 1..7 of a frame are kept: type code plus three axis words
   localparam int FB_DEPTH = 7;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   typedef enum logic [1:0] {
      ST_WAIT = 2'd0,
      ST_FAIL = 2'd1,
      ST_DONE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_ACCEL = 3'd1,
      KIND_RATE  = 3'd2,
      KIND_ANGLE = 3'd3,
      KIND_OTHER = 3'd4
   } kind_type;

   // per-word outcome handed from the frame tracker to the result register
   typedef struct packed {
      status_type status;
      kind_type   kind;
   } evt_type;

   // x, y, z raw counts, x in element 0
   typedef logic [2:0][15:0] axes_type;

endpackage

`default_nettype wire

// File: design/imu_sfp_frame.sv
// ----------------------------------------------------------------------------
// imu_sfp_frame
// Byte counter, frame byte store and latest-value sets of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sfp_frame #(
   parameter int FRAME_LEN = imu_sfp_pkg::FRAME_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_en,
   input  logic [7:0]            rx_byte,
   output imu_sfp_pkg::evt_type  evt,
   output imu_sfp_pkg::axes_type accel,
   output imu_sfp_pkg::axes_type rate,
   output imu_sfp_pkg::axes_type angle
);

   localparam logic [4:0] LAST_COUNT = 5'(FRAME_LEN);

   logic [3:0]            count_ff, count_in;
   logic [4:0]            count_next;
   logic [7:0]            fb_ff [imu_sfp_pkg::FB_DEPTH];
   imu_sfp_pkg::axes_type accel_ff, accel_in;
   imu_sfp_pkg::axes_type rate_ff, rate_in;
   imu_sfp_pkg::axes_type angle_ff, angle_in;
   imu_sfp_pkg::axes_type frame_axes;
   logic                  hdr_bad;
   logic                  frame_end;
   logic                  fb_wr;

   always_comb begin
      count_next = {1'b0, count_ff} + 5'd1;
      hdr_bad    = (count_ff == 4'd0) && (rx_byte != imu_sfp_pkg::HDR_BYTE);
      frame_end  = !hdr_bad && (count_next >= LAST_COUNT);
      fb_wr      = !hdr_bad && (count_ff != 4'd0) &&
                   (count_ff <= 4'(imu_sfp_pkg::FB_DEPTH));

      // little endian: low byte first
      for (int k = 0; k < 3; k++) begin
         frame_axes[k] = {fb_ff[2 + 2 * k], fb_ff[1 + 2 * k]};
      end

      evt.status = imu_sfp_pkg::ST_WAIT;
      evt.kind   = imu_sfp_pkg::KIND_NONE;
      count_in   = count_next[3:0];
      accel_in   = accel_ff;
      rate_in    = rate_ff;
      angle_in   = angle_ff;

      if (hdr_bad) begin
         evt.status = imu_sfp_pkg::ST_FAIL;
         count_in   = 4'd0;
      end else if (frame_end) begin
         evt.status = imu_sfp_pkg::ST_DONE;
         count_in   = 4'd0;
         case (fb_ff[0])
            imu_sfp_pkg::TYPE_ACCEL: begin
               evt.kind = imu_sfp_pkg::KIND_ACCEL;
               accel_in = frame_axes;
            end
            imu_sfp_pkg::TYPE_RATE: begin
               evt.kind = imu_sfp_pkg::KIND_RATE;
               rate_in  = frame_axes;
            end
            imu_sfp_pkg::TYPE_ANGLE: begin
               evt.kind = imu_sfp_pkg::KIND_ANGLE;
               angle_in = frame_axes;
            end
            default: begin
               evt.kind = imu_sfp_pkg::KIND_OTHER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         accel_ff <= '0;
         rate_ff  <= '0;
         angle_ff <= '0;
      end else if (byte_en) begin
         count_ff <= count_in;
         accel_ff <= accel_in;
         rate_ff  <= rate_in;
         angle_ff <= angle_in;
      end
   end

   // frame byte n lands in entry n-1; no reset, always written before use
   always_ff @(posedge clock) begin
      if (byte_en && fb_wr) begin
         fb_ff[3'(count_ff - 4'd1)] <= rx_byte;
      end
   end

   assign accel = accel_ff;
   assign rate  = rate_ff;
   assign angle = angle_ff;

   // count never reaches the frame length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} < LAST_COUNT))
      else $error("byte count out of range");

   // a completed frame restarts at the header
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (byte_en && evt.status == imu_sfp_pkg::ST_DONE) |=> (count_ff == 4'd0))
      else $error("count not cleared after frame end");

   a_accel_hold: assert property (@(posedge clock) disable iff (reset)
      !(byte_en && evt.kind == imu_sfp_pkg::KIND_ACCEL) |=> $stable(accel_ff))
      else $error("accel set changed without accel frame");

   a_rate_hold: assert property (@(posedge clock) disable iff (reset)
      !(byte_en && evt.kind == imu_sfp_pkg::KIND_RATE) |=> $stable(rate_ff))
      else $error("rate set changed without rate frame");

   a_angle_hold: assert property (@(posedge clock) disable iff (reset)
      !(byte_en && evt.kind == imu_sfp_pkg::KIND_ANGLE) |=> $stable(angle_ff))
      else $error("angle set changed without angle frame");

endmodule

`default_nettype wire

// File: design/imu_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// Assembles FRAME_LEN-byte IMU frames from received serial bytes, one word
// per received byte. A frame opens with 0x55; any other opening byte is
// dropped with status 1. On the last byte, byte 1 picks the set that bytes
// 2..7 (three little-endian signed words x, y, z) replace: 0x51 accel,
// 0x52 angular rate, 0x53 angle; other codes end the frame with kind 4 and
// change nothing. Checksum and temperature are not checked. Each request
// word returns exactly one response word: status (0 in progress, 1 header
// dropped, 2 frame complete), frame kind and all nine latest values, already
// updated by a completing frame. All sets read zero after reset. Rate: one
// word per cycle unless responses stall; responses are registered. Requests
// are taken while the response register is empty or drained the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_serial_frame_parser #(
   parameter int FRAME_LEN = imu_sfp_pkg::FRAME_LEN_DEF   // 9 .. 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel: received bytes
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_frame_kind,
   output logic signed [15:0] rsp_accel_x,
   output logic signed [15:0] rsp_accel_y,
   output logic signed [15:0] rsp_accel_z,
   output logic signed [15:0] rsp_rate_x,
   output logic signed [15:0] rsp_rate_y,
   output logic signed [15:0] rsp_rate_z,
   output logic signed [15:0] rsp_angle_x,
   output logic signed [15:0] rsp_angle_y,
   output logic signed [15:0] rsp_angle_z
);

   logic                  req_take;
   logic                  rsp_valid_ff, rsp_valid_in;
   imu_sfp_pkg::evt_type  evt_ff, evt_in;
   imu_sfp_pkg::axes_type accel;
   imu_sfp_pkg::axes_type rate;
   imu_sfp_pkg::axes_type angle;

   // response slot frees up in the same cycle it is drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // the latest-value sets only move on a taken word, so they double as the
   // payload half of the response register
   imu_sfp_frame #(
      .FRAME_LEN (FRAME_LEN)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .byte_en (req_take),
      .rx_byte (req_rx_byte),
      .evt     (evt_in),
      .accel   (accel),
      .rate    (rate),
      .angle   (angle)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status / kind of the word in the response slot
   always_ff @(posedge clock) begin
      if (req_take) begin
         evt_ff <= evt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = evt_ff.status;
   assign rsp_frame_kind = evt_ff.kind;
   assign rsp_accel_x    = $signed(accel[0]);
   assign rsp_accel_y    = $signed(accel[1]);
   assign rsp_accel_z    = $signed(accel[2]);
   assign rsp_rate_x     = $signed(rate[0]);
   assign rsp_rate_y     = $signed(rate[1]);
   assign rsp_rate_z     = $signed(rate[2]);
   assign rsp_angle_x    = $signed(angle[0]);
   assign rsp_angle_y    = $signed(angle[1]);
   assign rsp_angle_z    = $signed(angle[2]);

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for imu_serial_frame_parser. A driver feeds received
// bytes from a queue and a local frame tracker predicts the response word
// each accepted byte must produce; a monitor checks every response word,
// field by field, against the oldest prediction. Both sides idle in random
// bursts except in the tail of the run.
// ----------------------------------------------------------------------------

module tb;

   // no idling once fewer bytes than this are left to send
   localparam int TAIL_CALM = 150;
   localparam int RX_TARGET = 1100;

   // one predicted response word
   typedef struct packed {
      imu_sfp_pkg::status_type status;
      imu_sfp_pkg::kind_type   kind;
      imu_sfp_pkg::axes_type   accel;
      imu_sfp_pkg::axes_type   rate;
      imu_sfp_pkg::axes_type   angle;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [1:0]        rsp_status;
   logic [2:0]        rsp_frame_kind;
   logic signed [15:0] rsp_accel_x, rsp_accel_y, rsp_accel_z;
   logic signed [15:0] rsp_rate_x, rsp_rate_y, rsp_rate_z;
   logic signed [15:0] rsp_angle_x, rsp_angle_y, rsp_angle_z;

   // bytes waiting to be sent, and response words still due
   logic [7:0]   rx_byte_q[$];
   rsp_word_type rsp_due_q[$];
   int           fail_cnt = 0;

   // local copy of the frame tracker and the latest-value sets
   logic [3:0]            frame_pos;
   logic [7:0]            frame_store[imu_sfp_pkg::FB_DEPTH];
   imu_sfp_pkg::axes_type accel_now, rate_now, angle_now;

   imu_serial_frame_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_accel_x    (rsp_accel_x),
      .rsp_accel_y    (rsp_accel_y),
      .rsp_accel_z    (rsp_accel_z),
      .rsp_rate_x     (rsp_rate_x),
      .rsp_rate_y     (rsp_rate_y),
      .rsp_rate_z     (rsp_rate_z),
      .rsp_angle_x    (rsp_angle_x),
      .rsp_angle_y    (rsp_angle_y),
      .rsp_angle_z    (rsp_angle_z)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // frame bytes 2..7 -> x, y, z, low byte first
   function automatic imu_sfp_pkg::axes_type axes_from_frame();
      imu_sfp_pkg::axes_type a;
      for (int k = 0; k < 3; k++)
         a[k] = {frame_store[2 + 2 * k], frame_store[1 + 2 * k]};
      return a;
   endfunction

   // advance the tracker by one received byte and queue the word it causes
   task automatic parse_byte(input logic [7:0] b);
      rsp_word_type w;
      int           n;
      w.status = imu_sfp_pkg::ST_WAIT;
      w.kind   = imu_sfp_pkg::KIND_NONE;
      if (frame_pos == 4'd0 && b != imu_sfp_pkg::HDR_BYTE) begin
         // bad opening byte: dropped, tracker stays at the start
         w.status = imu_sfp_pkg::ST_FAIL;
      end else begin
         n = int'(frame_pos) + 1;
         // only bytes 1..7 are kept; header, temperature, checksum are not
         if (frame_pos >= 4'd1 && frame_pos <= 4'd7)
            frame_store[frame_pos - 4'd1] = b;
         if (n >= imu_sfp_pkg::FRAME_LEN_DEF) begin
            case (frame_store[0])
               imu_sfp_pkg::TYPE_ACCEL: begin
                  accel_now = axes_from_frame();
                  w.kind    = imu_sfp_pkg::KIND_ACCEL;
               end
               imu_sfp_pkg::TYPE_RATE: begin
                  rate_now = axes_from_frame();
                  w.kind   = imu_sfp_pkg::KIND_RATE;
               end
               imu_sfp_pkg::TYPE_ANGLE: begin
                  angle_now = axes_from_frame();
                  w.kind    = imu_sfp_pkg::KIND_ANGLE;
               end
               default: w.kind = imu_sfp_pkg::KIND_OTHER;
            endcase
            w.status  = imu_sfp_pkg::ST_DONE;
            frame_pos = 4'd0;
         end else begin
            frame_pos = n[3:0];
         end
      end
      // values shown already include this byte's update
      w.accel = accel_now;
      w.rate  = rate_now;
      w.angle = angle_now;
      rsp_due_q.push_back(w);
   endtask

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------

   // axis count, leaning on the extremes now and then
   function automatic logic [15:0] axis_word();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // one full frame: header, type, x/y/z, temperature, checksum
   task automatic queue_frame(input logic [7:0] code, input imu_sfp_pkg::axes_type ax,
                              input logic [7:0] tail0, input logic [7:0] tail1,
                              input logic [7:0] tail2);
      rx_byte_q.push_back(imu_sfp_pkg::HDR_BYTE);
      rx_byte_q.push_back(code);
      for (int k = 0; k < 3; k++) begin
         rx_byte_q.push_back(ax[k][7:0]);
         rx_byte_q.push_back(ax[k][15:8]);
      end
      rx_byte_q.push_back(tail0);
      rx_byte_q.push_back(tail1);
      rx_byte_q.push_back(tail2);
   endtask

   function automatic logic [7:0] frame_code();
      case ($urandom_range(0, 9))
         0, 1, 2: return imu_sfp_pkg::TYPE_ACCEL;
         3, 4, 5: return imu_sfp_pkg::TYPE_RATE;
         6, 7, 8: return imu_sfp_pkg::TYPE_ANGLE;
         default: return 8'($urandom);   // mostly an unknown type
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // driver: send queued bytes, idling in random bursts
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drv
      int unsigned req_gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
         frame_pos = 4'd0;
         accel_now = '0;
         rate_now  = '0;
         angle_now = '0;
      end else begin
         if (req_valid && req_ready)
            parse_byte(req_rx_byte);
         // payload may only change once the current word has gone
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (rx_byte_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (rx_byte_q.size() >= TAIL_CALM && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 11);
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_byte_q.pop_front();
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: check response words, stalling in random bursts
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
         fail_cnt++;
      end
   endtask

   always @(posedge clock) begin : mon
      int unsigned  rsp_hold;
      rsp_word_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due_q.size() == 0) begin
               $display("%0t ns: response word with none due, expected nothing, got status %h",
                        $time, rsp_status);
               fail_cnt++;
            end else begin
               w = rsp_due_q.pop_front();
               check_field("status",     16'(w.status),   16'(rsp_status));
               check_field("frame_kind", 16'(w.kind),     16'(rsp_frame_kind));
               check_field("accel_x",    w.accel[0],      rsp_accel_x);
               check_field("accel_y",    w.accel[1],      rsp_accel_y);
               check_field("accel_z",    w.accel[2],      rsp_accel_z);
               check_field("rate_x",     w.rate[0],       rsp_rate_x);
               check_field("rate_y",     w.rate[1],       rsp_rate_y);
               check_field("rate_z",     w.rate[2],       rsp_rate_z);
               check_field("angle_x",    w.angle[0],      rsp_angle_x);
               check_field("angle_y",    w.angle[1],      rsp_angle_y);
               check_field("angle_z",    w.angle[2],      rsp_angle_z);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_byte_q.size() >= TAIL_CALM && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequence: build all stimulus, reset, drain, report
   // ---------------------------------------------------------------------
   initial begin
      imu_sfp_pkg::axes_type ax;
      int                    n;

      // directed: bad opening bytes at both ends of the range
      rx_byte_q.push_back(8'h00);
      rx_byte_q.push_back(8'hFF);
      // accel frame with extreme counts; 0x55 inside the frame is just data
      ax[0] = 16'h8000;
      ax[1] = 16'h7FFF;
      ax[2] = 16'hFFFF;
      queue_frame(imu_sfp_pkg::TYPE_ACCEL, ax, 8'h55, 8'h55, 8'h00);
      // unknown type (0x55 as type code) completes but changes nothing
      ax[0] = 16'h1234;
      ax[1] = 16'h0000;
      ax[2] = 16'h5555;
      queue_frame(imu_sfp_pkg::HDR_BYTE, ax, 8'hFF, 8'h00, 8'hAA);

      // random: mostly well-formed frames, some noise and cut-off frames
      while (rx_byte_q.size() < RX_TARGET) begin
         case ($urandom_range(0, 9))
            0: rx_byte_q.push_back(8'($urandom));           // lone noise byte
            1: begin
               // truncated frame; whatever follows fills it up
               rx_byte_q.push_back(imu_sfp_pkg::HDR_BYTE);
               n = $urandom_range(0, 9);
               for (int i = 0; i < n; i++)
                  rx_byte_q.push_back(8'($urandom));
            end
            default: begin
               for (int k = 0; k < 3; k++)
                  ax[k] = axis_word();
               queue_frame(frame_code(), ax, 8'($urandom), 8'($urandom),
                           8'($urandom));
            end
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for the last byte to go and its response word to come back
      while (rx_byte_q.size() != 0 || req_valid || rsp_due_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (fail_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #2500000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: imu_serial_frame_parser.f
design/imu_sfp_pkg.sv
design/imu_sfp_frame.sv
design/imu_serial_frame_parser.sv
tb/tb.sv
